>>> sv/hdrt_pkg.sv
// ============================================================================
// hdrt_pkg
// Shared constants and the elaboration-time gamma threshold function for the
// HDR pixel tone mapper.
// ============================================================================
package hdrt_pkg;

    // IEEE single-precision field layout
    localparam int MAN_W      = 24;          // mantissa with hidden bit
    localparam int EXP_BIAS_M = 150;         // bias + 23 fraction bits
    localparam logic [7:0] EXP_ALL_ONE = 8'hFF;
    localparam logic [7:0] BYTE_MAX    = 8'hFF;

    // Smallest index i in 0..2^g-1 whose gamma byte reaches b, that is with
    // (2b-1)^11 * 2^(5g) <= 255^11 * i^5 * 2^11; 2^g when no index does.
    function automatic logic [16:0] gamma_thresh(input int g, input int b);
        logic [255:0] rhs;
        logic [255:0] base;
        logic [255:0] lhs;
        int lo;
        int hi;
        int mid;
        rhs  = 256'd1;
        base = 256'd1;
        lo   = 0;
        hi   = 1 << g;
        if (b == 0) begin
            return 17'd0;
        end
        for (int n = 0; n < 11; n++) begin
            rhs  = rhs * 256'(2 * b - 1);
            base = base * 256'd255;
        end
        rhs  = rhs << (5 * g);
        base = base << 11;
        for (int it = 0; it < 20; it++) begin
            if (lo < hi) begin
                mid = (lo + hi) >> 1;
                lhs = base;
                for (int n = 0; n < 5; n++) begin
                    lhs = lhs * 256'(mid);
                end
                if (rhs <= lhs) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
        end
        return 17'(lo);
    endfunction

endpackage

>>> sv/hdrt_colour.sv
// ============================================================================
// hdrt_colour
// One colour channel: float decode, pipelined restoring divide for
// x/(1+x) in fixed point, then a staged binary search of the gamma table.
// ============================================================================
module hdrt_colour
    import hdrt_pkg::*;
#(
    parameter int FRAC_BITS      = 16,
    parameter int GAMMA_LUT_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_bits,
    output logic [7:0]  o_byte
);

    localparam int DW   = MAN_W + FRAC_BITS;   // divisor width
    localparam int G    = GAMMA_LUT_BITS;
    localparam int TH_W = G + 1;

    // gamma thresholds, one per output byte
    logic [TH_W-1:0] w_thr [256];
    for (genvar b = 0; b < 256; b++) begin : g_thr
        localparam logic [TH_W-1:0] T_B = TH_W'(gamma_thresh(G, b));
        assign w_thr[b] = T_B;
    end

    // ------------------------------------------------------------------
    // decode: reduce to floor(2^F * a / d) with a < d
    // ------------------------------------------------------------------
    logic [7:0]    w_ex;
    logic [MAN_W-1:0] w_mm;
    logic [7:0]    w_es;
    logic [7:0]    w_k;
    logic [47:0]   w_t;
    logic [DW-1:0] n_rem0;
    logic [DW-1:0] n_den0;

    always_comb begin
        w_ex   = i_bits[30:23];
        w_mm   = {(w_ex != 8'd0), i_bits[22:0]};
        w_es   = w_ex - 8'(EXP_BIAS_M);
        w_k    = (w_ex == 8'd0) ? 8'(EXP_BIAS_M - 1) : 8'(EXP_BIAS_M) - w_ex;
        w_t    = {24'd0, w_mm} << w_es[4:0];
        n_rem0 = '0;
        n_den0 = DW'(1);
        if (w_ex == EXP_ALL_ONE || i_bits[31] || i_bits[30:0] == 31'd0) begin
            // non-finite, zero or negative: result 0
            n_rem0 = '0;
            n_den0 = DW'(1);
        end else if (w_ex >= 8'(EXP_BIAS_M)) begin
            if (w_es >= 8'd24 || (|w_t[47:FRAC_BITS])) begin
                // saturate: a/(a+1) with a = 2^F-1 gives 2^F-1
                n_rem0 = DW'({FRAC_BITS{1'b1}});
                n_den0 = DW'(1) << FRAC_BITS;
            end else begin
                n_rem0 = DW'(w_t[FRAC_BITS-1:0]);
                n_den0 = DW'(w_t[FRAC_BITS-1:0]) + DW'(1);
            end
        end else if (w_k < 8'(MAN_W + FRAC_BITS)) begin
            n_rem0 = DW'(w_mm);
            n_den0 = DW'(w_mm) + (DW'(1) << w_k);
        end
    end

    // ------------------------------------------------------------------
    // divider: one quotient bit per stage
    // ------------------------------------------------------------------
    logic [DW-1:0]        r_rem [FRAC_BITS+1];
    logic [DW-1:0]        r_den [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] r_quo [FRAC_BITS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem0;
            r_den[0] <= n_den0;
            r_quo[0] <= '0;
        end
    end

    for (genvar s = 0; s < FRAC_BITS; s++) begin : g_div
        logic [DW:0] w_r2;
        logic [DW:0] w_diff;
        logic        w_take;
        assign w_r2   = {r_rem[s], 1'b0};
        assign w_diff = w_r2 - {1'b0, r_den[s]};
        assign w_take = (w_r2 >= {1'b0, r_den[s]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_take ? w_diff[DW-1:0] : w_r2[DW-1:0];
                r_den[s+1] <= r_den[s];
                r_quo[s+1] <= {r_quo[s][FRAC_BITS-2:0], w_take};
            end
        end
    end

    // table index: top G bits of y (shifted up when F < G)
    logic [FRAC_BITS+G-1:0] w_wide;
    logic [G-1:0]           w_idx;
    assign w_wide = {r_quo[FRAC_BITS], {G{1'b0}}};
    assign w_idx  = w_wide[FRAC_BITS+G-1:FRAC_BITS];

    // ------------------------------------------------------------------
    // gamma search: one result bit per stage, MSB first
    // ------------------------------------------------------------------
    logic [7:0]   r_acc [8];
    logic [G-1:0] r_gi  [8];

    for (genvar s = 0; s < 8; s++) begin : g_gam
        logic [7:0]   w_acc_in;
        logic [G-1:0] w_gi_in;
        logic [7:0]   w_cand;
        if (s == 0) begin : g_first
            assign w_acc_in = 8'd0;
            assign w_gi_in  = w_idx;
        end else begin : g_next
            assign w_acc_in = r_acc[s-1];
            assign w_gi_in  = r_gi[s-1];
        end
        assign w_cand = w_acc_in | (8'd1 << (7 - s));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[s] <= (w_thr[w_cand] <= {1'b0, w_gi_in}) ? w_cand : w_acc_in;
                r_gi[s]  <= w_gi_in;
            end
        end
    end

    assign o_byte = r_acc[7];

endmodule

>>> sv/hdr_pixel_tonemap.sv
// Path: input transfer, entry register, divider stages, gamma search stages, result.
// Throughput: one pixel per cycle; the F-stage divider and 8-stage gamma search
//   are fully pipelined, so a stall at the output freezes the whole pipe.
// Reset: synchronous, active low; clears the valid bits only.
// ============================================================================
// hdr_pixel_tonemap
// Reinhard tone mapping with 2.2 display gamma for RGBA float pixels.
// ============================================================================
module hdr_pixel_tonemap
    import hdrt_pkg::*;
#(
    parameter int FRAC_BITS      = 16,
    parameter int GAMMA_LUT_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_red_bits,
    input  logic [31:0] i_green_bits,
    input  logic [31:0] i_blue_bits,
    input  logic [31:0] i_alpha_bits,
    input  logic        i_last_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red_byte,
    output logic [7:0]  o_green_byte,
    output logic [7:0]  o_blue_byte,
    output logic [7:0]  o_alpha_byte,
    output logic        o_last_out
);

    localparam int LAT = FRAC_BITS + 9;

    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // colour channels
    hdrt_colour #(.FRAC_BITS(FRAC_BITS), .GAMMA_LUT_BITS(GAMMA_LUT_BITS)) u_red (
        .i_clk(i_clk), .i_en(w_en), .i_bits(i_red_bits), .o_byte(o_red_byte));
    hdrt_colour #(.FRAC_BITS(FRAC_BITS), .GAMMA_LUT_BITS(GAMMA_LUT_BITS)) u_green (
        .i_clk(i_clk), .i_en(w_en), .i_bits(i_green_bits), .o_byte(o_green_byte));
    hdrt_colour #(.FRAC_BITS(FRAC_BITS), .GAMMA_LUT_BITS(GAMMA_LUT_BITS)) u_blue (
        .i_clk(i_clk), .i_en(w_en), .i_bits(i_blue_bits), .o_byte(o_blue_byte));

    // alpha: round(clamp(a,0,1)*255), computed at entry; an all-ones exponent gives 255
    logic [7:0]       w_aex;
    logic [MAN_W-1:0] w_amm;
    logic [7:0]       w_ak;
    logic [34:0]      w_anum;
    logic [34:0]      w_ashift;
    logic [7:0]       n_alpha;

    always_comb begin
        w_aex    = i_alpha_bits[30:23];
        w_amm    = {(w_aex != 8'd0), i_alpha_bits[22:0]};
        w_ak     = (w_aex == 8'd0) ? 8'(EXP_BIAS_M - 1) : 8'(EXP_BIAS_M) - w_aex;
        w_anum   = ({2'd0, w_amm, 9'd0} - {10'd0, w_amm, 1'b0}) + (35'd1 << w_ak[5:0]);
        w_ashift = w_anum >> (w_ak[5:0] + 6'd1);
        n_alpha  = w_ashift[7:0];
        if (w_aex == EXP_ALL_ONE) begin
            n_alpha = BYTE_MAX;
        end else if (i_alpha_bits[31] || i_alpha_bits[30:0] == 31'd0) begin
            n_alpha = 8'd0;
        end else if (w_aex >= 8'(EXP_BIAS_M)) begin
            n_alpha = BYTE_MAX;
        end else if (w_ak < 8'd24 && {1'b0, w_amm} >= (25'd1 << w_ak[4:0])) begin
            n_alpha = BYTE_MAX;
        end else if (w_ak >= 8'd34) begin
            n_alpha = 8'd0;
        end
    end

    // side pipe: valid, last flag, alpha
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_last;
    logic [7:0]     r_alpha [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last   <= {r_last[LAT-2:0], i_last_pixel};
            r_alpha[0] <= n_alpha;
            for (int s = 1; s < LAT; s++) begin
                r_alpha[s] <= r_alpha[s-1];
            end
        end
    end

    assign o_valid      = r_vld[LAT-1];
    assign o_last_out   = r_last[LAT-1];
    assign o_alpha_byte = r_alpha[LAT-1];

endmodule

>>> sv/hdrt_check.sv
// ============================================================================
// hdrt_check
// Port-level checks for the tone mapper output channel, input stall and reset.
// ============================================================================
module hdrt_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_red_byte,
    input logic [7:0]  o_green_byte,
    input logic [7:0]  o_blue_byte,
    input logic [7:0]  o_alpha_byte,
    input logic        o_last_out
);

    // held result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // input side stalls exactly when the output is blocked
    a_stall_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output back-pressure");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present right after reset");

    // no input taken while the pipe is frozen means the held result is unchanged
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_red_byte, o_green_byte, o_blue_byte,
                                         o_alpha_byte, o_last_out}))
        else $error("held result changed");

endmodule

bind hdr_pixel_tonemap hdrt_check u_check (.*);
